// ===== hdl/vau_pkg.sv =====
// shared types, constants and arithmetic helpers for the vector unit
`timescale 1ns / 1ps

package vau_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int SQ_STAGES  = 32;
    localparam int QW         = FRAC_BITS + 1;
    localparam int DIV_STAGES = QW;
    localparam int SIDE_DEPTH = SQ_STAGES + DIV_STAGES;
    localparam int PIPE_DEPTH = 2 + SIDE_DEPTH;

    localparam logic signed [65:0] SAT_MAX = 66'sh0_0000_0000_7fff_ffff;
    localparam logic signed [65:0] SAT_MIN = 66'sh3_ffff_ffff_8000_0000;

    typedef enum logic [2:0] {
        ACT_ADD   = 3'd0,
        ACT_SUB   = 3'd1,
        ACT_SCALE = 3'd2,
        ACT_MUL   = 3'd3,
        ACT_NORM  = 3'd4,
        ACT_DOT   = 3'd5,
        ACT_CROSS = 3'd6,
        ACT_NONE  = 3'd7
    } action_t;

    typedef struct packed {
        logic signed [63:0] p0;
        logic signed [63:0] p1;
        logic signed [32:0] s;
    } lane_res_t;

    typedef struct packed {
        logic [31:0] v;
        logic        ovf;
    } comp_t;

    typedef struct packed {
        logic             norm;
        logic             zlen;
        logic [2:0][31:0] res;
        logic             ovf;
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
    } side_t;

    function automatic logic signed [65:0] ext64(input logic signed [63:0] p);
        return {{2{p[63]}}, p};
    endfunction

    // round half up to FRAC_BITS fraction bits
    function automatic logic signed [65:0] rnd_frac(input logic signed [65:0] t);
        logic signed [65:0] h;
        h = t + (66'sd1 <<< (FRAC_BITS - 1));
        return h >>> FRAC_BITS;
    endfunction

    function automatic comp_t sat32(input logic signed [65:0] v);
        comp_t c;
        if (v > SAT_MAX)
        begin
            c.v   = 32'h7fff_ffff;
            c.ovf = 1'b1;
        end
        else if (v < SAT_MIN)
        begin
            c.v   = 32'h8000_0000;
            c.ovf = 1'b1;
        end
        else
        begin
            c.v   = v[31:0];
            c.ovf = 1'b0;
        end
        return c;
    endfunction

endpackage

// ===== hdl/vau_in_if.sv =====
// input word channel of the vector unit
`timescale 1ns / 1ps

interface vau_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scale;

    modport source (output valid, action, a_x, a_y, a_z, b_x, b_y, b_z, scale,
                    input ready);
    modport sink (input valid, action, a_x, a_y, a_z, b_x, b_y, b_z, scale,
                  output ready);
endinterface

// ===== hdl/vau_out_if.sv =====
// result word channel of the vector unit
`timescale 1ns / 1ps

interface vau_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic               overflow;
    logic               zero_length;

    modport source (output valid, r_x, r_y, r_z, overflow, zero_length,
                    input ready);
    modport sink (input valid, r_x, r_y, r_z, overflow, zero_length,
                  output ready);
endinterface

// ===== hdl/vau_lane.sv =====
// one component lane: two registered multipliers and an adder
`timescale 1ns / 1ps

module vau_lane import vau_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] op0a,
    input  logic signed [31:0] op0b,
    input  logic signed [31:0] op1a,
    input  logic signed [31:0] op1b,
    input  logic signed [31:0] sa,
    input  logic signed [31:0] sb,
    input  logic               sub,
    output lane_res_t          res
);

    lane_res_t res_reg;
    lane_res_t res_next;

    always_comb
    begin
        res_next.p0 = op0a * op0b;
        res_next.p1 = op1a * op1b;
        if (sub)
            res_next.s = 33'(sa) - 33'(sb);
        else
            res_next.s = 33'(sa) + 33'(sb);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// ===== hdl/vau_merge.sv =====
// merge stage: combines lane results, rounds and saturates
`timescale 1ns / 1ps

module vau_merge import vau_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  action_t          act,
    input  lane_res_t [2:0]  ln,
    input  logic [2:0]       neg,
    input  logic [2:0][31:0] mag,
    output side_t            side,
    output logic [63:0]      sq
);

    side_t       side_reg;
    side_t       side_next;
    logic [63:0] sq_reg;
    logic [63:0] sq_next;
    comp_t       c [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            c[i] = '0;
        sq_next        = ln[0].p0 + ln[1].p0 + ln[2].p0;
        side_next.norm = 1'b0;
        side_next.zlen = 1'b0;
        side_next.neg  = neg;
        side_next.mag  = mag;
        case (act) inside
            ACT_ADD, ACT_SUB:
            begin
                for (int i = 0; i < 3; i++)
                    c[i] = sat32({{33{ln[i].s[32]}}, ln[i].s});
            end
            ACT_SCALE, ACT_MUL:
            begin
                for (int i = 0; i < 3; i++)
                    c[i] = sat32(rnd_frac(ext64(ln[i].p0)));
            end
            ACT_CROSS:
            begin
                for (int i = 0; i < 3; i++)
                    c[i] = sat32(rnd_frac(ext64(ln[i].p0) - ext64(ln[i].p1)));
            end
            ACT_DOT:
            begin
                c[0] = sat32(rnd_frac(ext64(ln[0].p0) + ext64(ln[1].p0)
                                      + ext64(ln[2].p0)));
            end
            ACT_NORM:
            begin
                side_next.norm = 1'b1;
                side_next.zlen = (sq_next == 64'd0);
            end
            default:
            begin
                side_next.norm = 1'b0;
            end
        endcase
        for (int i = 0; i < 3; i++)
            side_next.res[i] = c[i].v;
        side_next.ovf = c[0].ovf | c[1].ovf | c[2].ovf;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_next;
            sq_reg   <= sq_next;
        end
    end

    assign side = side_reg;
    assign sq   = sq_reg;

endmodule

// ===== hdl/vau_isqrt.sv =====
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps

module vau_isqrt import vau_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] sq,
    output logic [31:0] root
);

    logic [63:0] x_reg  [SQ_STAGES];
    logic [63:0] r_reg  [SQ_STAGES];
    logic [63:0] x_next [SQ_STAGES];
    logic [63:0] r_next [SQ_STAGES];
    logic [63:0] x_prev [SQ_STAGES];
    logic [63:0] r_prev [SQ_STAGES];
    logic [63:0] trial  [SQ_STAGES];

    always_comb
    begin
        for (int k = 0; k < SQ_STAGES; k++)
        begin
            x_prev[k] = (k == 0) ? sq : x_reg[(k == 0) ? 0 : k - 1];
            r_prev[k] = (k == 0) ? 64'd0 : r_reg[(k == 0) ? 0 : k - 1];
            trial[k]  = r_prev[k] + (64'd1 << (62 - 2 * k));
            if (x_prev[k] >= trial[k])
            begin
                x_next[k] = x_prev[k] - trial[k];
                r_next[k] = (r_prev[k] >> 1) + (64'd1 << (62 - 2 * k));
            end
            else
            begin
                x_next[k] = x_prev[k];
                r_next[k] = r_prev[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQ_STAGES; k++)
            begin
                x_reg[k] <= x_next[k];
                r_reg[k] <= r_next[k];
            end
        end
    end

    assign root = r_reg[SQ_STAGES - 1][31:0];

endmodule

// ===== hdl/vau_ndiv.sv =====
// pipelined restoring divider for one normalised component
`timescale 1ns / 1ps

module vau_ndiv import vau_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        mag,
    input  logic               neg,
    input  logic [31:0]        len,
    output logic signed [31:0] q_out
);

    logic [63:0]   rem_reg  [DIV_STAGES];
    logic [QW-1:0] q_reg    [DIV_STAGES];
    logic [33:0]   d_reg    [DIV_STAGES];
    logic          neg_reg  [DIV_STAGES];
    logic [63:0]   rem_next [DIV_STAGES];
    logic [QW-1:0] q_next   [DIV_STAGES];
    logic [63:0]   rem_prev [DIV_STAGES];
    logic [QW-1:0] q_prev   [DIV_STAGES];
    logic [33:0]   d_prev   [DIV_STAGES];
    logic          neg_prev [DIV_STAGES];
    logic [63:0]   trial    [DIV_STAGES];
    logic [31:0]   qx;

    always_comb
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (k == 0)
            begin
                rem_prev[k] = ({32'd0, mag} << (FRAC_BITS + 1)) + {32'd0, len};
                q_prev[k]   = '0;
                d_prev[k]   = {1'b0, len, 1'b0};
                neg_prev[k] = neg;
            end
            else
            begin
                rem_prev[k] = rem_reg[(k == 0) ? 0 : k - 1];
                q_prev[k]   = q_reg[(k == 0) ? 0 : k - 1];
                d_prev[k]   = d_reg[(k == 0) ? 0 : k - 1];
                neg_prev[k] = neg_reg[(k == 0) ? 0 : k - 1];
            end
            trial[k]  = {30'd0, d_prev[k]} << (QW - 1 - k);
            q_next[k] = q_prev[k];
            if (rem_prev[k] >= trial[k])
            begin
                rem_next[k]            = rem_prev[k] - trial[k];
                q_next[k][QW - 1 - k]  = 1'b1;
            end
            else
            begin
                rem_next[k] = rem_prev[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
                d_reg[k]   <= d_prev[k];
                neg_reg[k] <= neg_prev[k];
            end
        end
    end

    assign qx    = {{(32 - QW){1'b0}}, q_reg[DIV_STAGES - 1]};
    assign q_out = neg_reg[DIV_STAGES - 1] ? -$signed(qx) : $signed(qx);

endmodule

// ===== hdl/vec3_arithmetic_unit.sv =====
// a word passes the lane, merge, square root, divider and output registers in order
// throughput: one word per cycle unless stalled; set by the sqrt and divider pipelines
// every word walks the full pipeline so results leave in order
// the whole pipeline holds while a result word waits to be taken
// reset clears the valid bits only; datapath registers are not reset
`timescale 1ns / 1ps

module vec3_arithmetic_unit import vau_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    vau_in_if.sink      in_ch,
    vau_out_if.source   out_ch
);

    logic                    adv;
    logic [PIPE_DEPTH-1:0]   vld_reg;
    logic                    out_vld_reg;
    logic signed [31:0]      rx_reg;
    logic signed [31:0]      ry_reg;
    logic signed [31:0]      rz_reg;
    logic                    ovf_reg;
    logic                    zlen_reg;
    logic signed [31:0]      rx_next;
    logic signed [31:0]      ry_next;
    logic signed [31:0]      rz_next;
    logic                    ovf_next;
    logic                    zlen_next;

    action_t                 act;
    action_t                 act_reg;
    logic [2:0]              neg_reg;
    logic [2:0][31:0]        mag_reg;
    logic signed [31:0]      av [3];
    logic signed [31:0]      bv [3];
    logic signed [31:0]      op0a [3];
    logic signed [31:0]      op0b [3];
    logic signed [31:0]      op1a [3];
    logic signed [31:0]      op1b [3];
    lane_res_t [2:0]         ln;
    side_t                   mside;
    logic [63:0]             msq;
    logic [31:0]             root;
    side_t                   sd_reg [SIDE_DEPTH];
    side_t                   fin;
    logic signed [31:0]      q [3];

    assign adv         = !out_vld_reg || out_ch.ready;
    assign in_ch.ready = adv;
    assign act         = action_t'(in_ch.action);

    always_comb
    begin
        av[0] = in_ch.a_x;
        av[1] = in_ch.a_y;
        av[2] = in_ch.a_z;
        bv[0] = in_ch.b_x;
        bv[1] = in_ch.b_y;
        bv[2] = in_ch.b_z;
        for (int i = 0; i < 3; i++)
        begin
            op1a[i] = av[(i + 1) % 3];
            op1b[i] = bv[(i + 1) % 3];
            case (act)
                ACT_SCALE:
                begin
                    op0a[i] = av[i];
                    op0b[i] = in_ch.scale;
                end
                ACT_NORM:
                begin
                    op0a[i] = av[i];
                    op0b[i] = av[i];
                end
                ACT_CROSS:
                begin
                    op0a[i] = av[(i + 1) % 3];
                    op0b[i] = bv[(i + 2) % 3];
                    op1a[i] = av[(i + 2) % 3];
                    op1b[i] = bv[(i + 1) % 3];
                end
                default:
                begin
                    op0a[i] = av[i];
                    op0b[i] = bv[i];
                end
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_lane
            vau_lane u_lane (
                .clk  (clk),
                .en   (adv),
                .op0a (op0a[g]),
                .op0b (op0b[g]),
                .op1a (op1a[g]),
                .op1b (op1b[g]),
                .sa   (av[g]),
                .sb   (bv[g]),
                .sub  (act == ACT_SUB),
                .res  (ln[g])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            act_reg <= act;
            for (int i = 0; i < 3; i++)
            begin
                neg_reg[i] <= av[i][31];
                mag_reg[i] <= av[i][31] ? 32'(-av[i]) : 32'(av[i]);
            end
        end
    end

    vau_merge u_merge (
        .clk  (clk),
        .en   (adv),
        .act  (act_reg),
        .ln   (ln),
        .neg  (neg_reg),
        .mag  (mag_reg),
        .side (mside),
        .sq   (msq)
    );

    vau_isqrt u_isqrt (
        .clk  (clk),
        .en   (adv),
        .sq   (msq),
        .root (root)
    );

    generate
        for (g = 0; g < 3; g++)
        begin : g_div
            vau_ndiv u_ndiv (
                .clk   (clk),
                .en    (adv),
                .mag   (sd_reg[SQ_STAGES - 1].mag[g]),
                .neg   (sd_reg[SQ_STAGES - 1].neg[g]),
                .len   (root),
                .q_out (q[g])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_reg[0] <= mside;
            for (int k = 1; k < SIDE_DEPTH; k++)
                sd_reg[k] <= sd_reg[k - 1];
        end
    end

    assign fin = sd_reg[SIDE_DEPTH - 1];

    always_comb
    begin
        if (fin.norm)
        begin
            ovf_next  = 1'b0;
            zlen_next = fin.zlen;
            if (fin.zlen)
            begin
                rx_next = '0;
                ry_next = '0;
                rz_next = '0;
            end
            else
            begin
                rx_next = q[0];
                ry_next = q[1];
                rz_next = q[2];
            end
        end
        else
        begin
            rx_next   = fin.res[0];
            ry_next   = fin.res[1];
            rz_next   = fin.res[2];
            ovf_next  = fin.ovf;
            zlen_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[PIPE_DEPTH-2:0], in_ch.valid};
            out_vld_reg <= vld_reg[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            rz_reg   <= rz_next;
            ovf_reg  <= ovf_next;
            zlen_reg <= zlen_next;
        end
    end

    assign out_ch.valid       = out_vld_reg;
    assign out_ch.r_x         = rx_reg;
    assign out_ch.r_y         = ry_reg;
    assign out_ch.r_z         = rz_reg;
    assign out_ch.overflow    = ovf_reg;
    assign out_ch.zero_length = zlen_reg;

endmodule

// ===== verif/vau_checker.sv =====
// checker: watches both word channels, predicts results and compares
`timescale 1ns / 1ps

module vau_checker import vau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    vau_in_if         in_ch,
    vau_out_if        out_ch,
    output int        fail_count,
    output int        pending
);

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               ovf;
        logic               zlen;
    } vres_t;

    vres_t result_q[$];

    function automatic logic signed [127:0] fdiv(input logic signed [127:0] v);
        return v >>> FRAC_BITS;
    endfunction

    function automatic logic signed [127:0] round_terms(input logic signed [127:0] t);
        return fdiv(t + (128'sd1 <<< (FRAC_BITS - 1)));
    endfunction

    function automatic logic signed [31:0] clip(input logic signed [127:0] v,
                                                inout logic sat);
        if (v > 128'sd2147483647)
        begin
            sat = 1'b1;
            return 32'sh7fff_ffff;
        end
        if (v < -128'sd2147483648)
        begin
            sat = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic vres_t predict_vector(input logic [2:0] act,
        input logic signed [31:0] ax, ay, az, bx, by, bz, sc);
        logic signed [127:0] a[3];
        logic signed [127:0] b[3];
        logic signed [127:0] r[3];
        logic [63:0] sq;
        logic [63:0] len;
        logic [127:0] mag;
        logic sat;
        vres_t o;
        a[0] = ax; a[1] = ay; a[2] = az;
        b[0] = bx; b[1] = by; b[2] = bz;
        r[0] = 0; r[1] = 0; r[2] = 0;
        sat = 0;
        o.zlen = 0;
        case (action_t'(act))
            ACT_ADD:   for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
            ACT_SUB:   for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
            ACT_SCALE: for (int i = 0; i < 3; i++) r[i] = round_terms(a[i] * sc);
            ACT_MUL:   for (int i = 0; i < 3; i++) r[i] = round_terms(a[i] * b[i]);
            ACT_DOT:   r[0] = round_terms(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
            ACT_CROSS:
            begin
                r[0] = round_terms(a[1] * b[2] - a[2] * b[1]);
                r[1] = round_terms(a[2] * b[0] - a[0] * b[2]);
                r[2] = round_terms(a[0] * b[1] - a[1] * b[0]);
            end
            ACT_NORM:
            begin
                sq = 64'(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
                if (sq == 0)
                    o.zlen = 1;
                else
                begin
                    len = int_sqrt(sq);
                    for (int i = 0; i < 3; i++)
                    begin
                        mag = (a[i] < 0) ? -a[i] : a[i];
                        mag = ((mag << FRAC_BITS) * 2 + len) / (2 * len);
                        r[i] = (a[i] < 0) ? -$signed(mag) : $signed(mag);
                    end
                end
            end
            default: ;
        endcase
        o.x = clip(r[0], sat);
        o.y = clip(r[1], sat);
        o.z = clip(r[2], sat);
        o.ovf = sat;
        return o;
    endfunction

    assign pending = result_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        vres_t e;
        if (!rst_n)
        begin
            fail_count <= 0;
            result_q.delete();
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                result_q.push_back(predict_vector(in_ch.action, in_ch.a_x, in_ch.a_y,
                    in_ch.a_z, in_ch.b_x, in_ch.b_y, in_ch.b_z, in_ch.scale));
            if (out_ch.valid && out_ch.ready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("unexpected result word");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = result_q.pop_front();
                    if (out_ch.r_x !== e.x || out_ch.r_y !== e.y || out_ch.r_z !== e.z
                        || out_ch.overflow !== e.ovf || out_ch.zero_length !== e.zlen)
                        fail_count <= fail_count + 1;
                    if (out_ch.r_x !== e.x)
                        $error("r_x expected %0d actual %0d", e.x, out_ch.r_x);
                    if (out_ch.r_y !== e.y)
                        $error("r_y expected %0d actual %0d", e.y, out_ch.r_y);
                    if (out_ch.r_z !== e.z)
                        $error("r_z expected %0d actual %0d", e.z, out_ch.r_z);
                    if (out_ch.overflow !== e.ovf)
                        $error("overflow expected %0b actual %0b", e.ovf, out_ch.overflow);
                    if (out_ch.zero_length !== e.zlen)
                        $error("zero_length expected %0b actual %0b", e.zlen,
                               out_ch.zero_length);
                end
            end
        end
    end

endmodule

// ===== verif/tb.sv =====
// testbench top: drives vector words through the unit and reports the verdict
`timescale 1ns / 1ps

module tb import vau_pkg::*;
;

    logic clk = 0;
    logic rst_n = 0;
    int   fail_count;
    int   pending;
    int   idle_pct = 0;
    int   stall_pct = 0;

    vau_in_if  in_ch();
    vau_out_if out_ch();

    vec3_arithmetic_unit u_top (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));
    vau_checker u_chk (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                       .fail_count(fail_count), .pending(pending));

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= stall_pct);

    function automatic logic signed [31:0] pick_val();
        case ($urandom_range(5))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return $signed($urandom_range(32'h0003_ffff)) - 32'sh0002_0000;
            3: return 0;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic [2:0] act,
        input logic signed [31:0] ax, ay, az, bx, by, bz, sc);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 0;
            @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.action <= act;
        in_ch.a_x <= ax; in_ch.a_y <= ay; in_ch.a_z <= az;
        in_ch.b_x <= bx; in_ch.b_y <= by; in_ch.b_z <= bz;
        in_ch.scale <= sc;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    initial
    begin
        logic signed [31:0] mx;
        logic signed [31:0] mn;
        in_ch.valid = 0;
        in_ch.action = 0;
        in_ch.a_x = 0; in_ch.a_y = 0; in_ch.a_z = 0;
        in_ch.b_x = 0; in_ch.b_y = 0; in_ch.b_z = 0;
        in_ch.scale = 0;
        mx = 32'sh7fff_ffff;
        mn = 32'sh8000_0000;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        for (int a = 0; a < 8; a++)
            send_word(3'(a), mx, mn, 32'sh0001_0000, mx, mx, mn, mn);
        for (int a = 0; a < 8; a++)
            send_word(3'(a), mn, mn, mn, mn, mn, mn, mx);
        send_word(ACT_NORM, 0, 0, 0, 1, 2, 3, 4);
        send_word(ACT_NORM, 1, 0, 0, 0, 0, 0, 0);
        send_word(ACT_NORM, -1, -1, -1, 0, 0, 0, 0);
        send_word(ACT_SCALE, 32'sh0000_8000, -32'sh0000_8000, 1, 0, 0, 0,
                  32'sh0000_0001);
        send_word(ACT_DOT, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                  32'sh0004_0000, 32'sh0005_0000, 32'sh0006_0000, 0);
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 10 : 82) : 0;
            stall_pct = (ph == 2) ? 82 : ((ph == 3) ? 10 : 0);
            repeat (150)
                send_word(3'($urandom_range(7)), pick_val(), pick_val(), pick_val(),
                          pick_val(), pick_val(), pick_val(), pick_val());
        end
        in_ch.valid <= 0;
        stall_pct = 0;
        while (pending != 0)
            @(posedge clk);
        repeat (2 * PIPE_DEPTH) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/vau_pkg.sv
hdl/vau_in_if.sv
hdl/vau_out_if.sv
hdl/vau_lane.sv
hdl/vau_merge.sv
hdl/vau_isqrt.sv
hdl/vau_ndiv.sv
hdl/vec3_arithmetic_unit.sv
verif/vau_checker.sv
verif/tb.sv
